[src/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// First-fit segment allocator package
// Request and response payloads, segment table entry, codes and states.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int LEN_W  = 11;
    localparam int ADDR_W = 10;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_COMPACT = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [LEN_W-1:0]  size;
        logic [ADDR_W-1:0] offset;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        status;
    } t_rsp;

    // One row of the segment table. The start is kept at full length width.
    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } t_seg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_FIN
    } t_state;

endpackage

[src/ffsa_seg_ram.sv]
// ----------------------------------------------------------------------------
// Segment table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffsa_seg_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ffsa_pkg::t_seg           i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ffsa_pkg::t_seg           o_rdata
);

    ffsa_pkg::t_seg r_mem [DEPTH];
    ffsa_pkg::t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/first_fit_segment_allocator.sv]
// ----------------------------------------------------------------------------
// First-fit segment allocator
// Compact scans the whole table before it responds; release may stop early at the matching row.
// Allocate runs a pipelined table scan, then for a split an entry shift and
// two row writes through the one write port.
// One request at a time; a new one is taken while the last response waits.
// After reset or a configuration size write the table is rebuilt as one free segment.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
    parameter int MEMORY_WORDS = 1024,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  ffsa_pkg::t_req                 i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output ffsa_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [ffsa_pkg::LEN_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int LW    = ffsa_pkg::LEN_W;

    localparam logic [LW-1:0] RESET_TOTAL =
        LW'((MEMORY_WORDS < 1024) ? MEMORY_WORDS : 1024);
    localparam logic [LW-1:0] MAX_TOTAL =
        LW'((MEMORY_WORDS < 2047) ? MEMORY_WORDS : 2047);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SEGMENTS);

    ffsa_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    ffsa_pkg::t_seg   r_hit, n_hit;
    ffsa_pkg::t_seg   r_acc, n_acc;
    ffsa_pkg::t_req   r_req, n_req;
    logic [1:0]       r_status, n_status;
    logic [LW-1:0]    r_addr, n_addr;
    logic [LW-1:0]    r_total, n_total;
    logic             r_rsp_vld, n_rsp_vld;
    ffsa_pkg::t_rsp   r_rsp, n_rsp;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    ffsa_pkg::t_seg   ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    ffsa_pkg::t_seg   ram_rdata;

    logic             issue;
    logic             accept;
    logic [LW-1:0]    cfg_val;

    ffsa_seg_ram #(
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_req_ready = (r_state == ffsa_pkg::S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_val = LW'(1);
        end else if (i_cfg_data > MAX_TOTAL) begin
            cfg_val = MAX_TOTAL;
        end else begin
            cfg_val = i_cfg_data;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_chk_vld = 1'b0;
        n_chk_idx = r_chk_idx;
        n_hit_idx = r_hit_idx;
        n_wr_idx  = r_wr_idx;
        n_hit     = r_hit;
        n_acc     = r_acc;
        n_req     = r_req;
        n_status  = r_status;
        n_addr    = r_addr;
        n_total   = r_total;
        n_rsp_vld = r_rsp_vld && !i_rsp_ready;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_rd_idx[IDX_W-1:0];
        issue     = 1'b0;

        case (r_state)
            ffsa_pkg::S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{start: '0, len: r_total, free: 1'b1};
                n_count   = CNT_W'(1);
                n_state   = ffsa_pkg::S_IDLE;
            end

            ffsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_req     = i_req;
                    n_status  = ffsa_pkg::ST_OK;
                    n_addr    = '0;
                    n_rd_idx  = '0;
                    n_wr_idx  = '0;
                    case (i_req.func)
                        ffsa_pkg::FUNC_ALLOC: begin
                            if (i_req.size == '0) begin
                                n_status = ffsa_pkg::ST_NO_FIT;
                                n_state  = ffsa_pkg::S_FIN;
                            end else begin
                                n_state = ffsa_pkg::S_SCAN;
                            end
                        end
                        ffsa_pkg::FUNC_RELEASE: n_state = ffsa_pkg::S_SCAN;
                        ffsa_pkg::FUNC_COMPACT: n_state = ffsa_pkg::S_SCAN;
                        default:                n_state = ffsa_pkg::S_FIN;
                    endcase
                end
            end

            // Reads run one row ahead of the row being examined.
            ffsa_pkg::S_SCAN: begin
                issue     = (r_rd_idx < r_count);
                n_chk_vld = issue;
                n_chk_idx = r_rd_idx[IDX_W-1:0];
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (r_chk_vld) begin
                    case (r_req.func)
                        ffsa_pkg::FUNC_ALLOC: begin
                            if (ram_rdata.free && ram_rdata.len >= r_req.size) begin
                                n_chk_vld = 1'b0;
                                n_state   = ffsa_pkg::S_FIN;
                                if (ram_rdata.len == r_req.size) begin
                                    ram_we         = 1'b1;
                                    ram_wdata.free = 1'b0;
                                    n_addr         = ram_rdata.start;
                                end else if (r_count == FULL_COUNT) begin
                                    n_status = ffsa_pkg::ST_TABLE_FULL;
                                end else begin
                                    n_hit     = ram_rdata;
                                    n_hit_idx = r_chk_idx;
                                    n_rd_idx  = r_count - CNT_W'(1);
                                    n_state   = ffsa_pkg::S_SHIFT;
                                end
                            end
                        end
                        ffsa_pkg::FUNC_RELEASE: begin
                            if (ram_rdata.start == LW'(r_req.offset)) begin
                                ram_we         = 1'b1;
                                ram_wdata.free = 1'b1;
                                n_chk_vld      = 1'b0;
                                n_state        = ffsa_pkg::S_FIN;
                            end
                        end
                        ffsa_pkg::FUNC_COMPACT: begin
                            if (r_chk_idx == '0) begin
                                n_acc = ram_rdata;
                            end else if (r_acc.free && ram_rdata.free) begin
                                n_acc.len = r_acc.len + ram_rdata.len;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_wr_idx;
                                ram_wdata = r_acc;
                                n_wr_idx  = r_wr_idx + IDX_W'(1);
                                n_acc     = ram_rdata;
                            end
                        end
                        default: n_state = ffsa_pkg::S_FIN;
                    endcase
                end else if (!issue) begin
                    // Table exhausted with nothing left in flight.
                    n_state = ffsa_pkg::S_FIN;
                    case (r_req.func)
                        ffsa_pkg::FUNC_ALLOC:   n_status = ffsa_pkg::ST_NO_FIT;
                        ffsa_pkg::FUNC_RELEASE: n_status = ffsa_pkg::ST_NOT_FOUND;
                        ffsa_pkg::FUNC_COMPACT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_wr_idx;
                            ram_wdata = r_acc;
                            n_count   = CNT_W'(r_wr_idx) + CNT_W'(1);
                        end
                        default: n_status = ffsa_pkg::ST_OK;
                    endcase
                end
            end

            // Move rows above the split point up by one, top row first.
            ffsa_pkg::S_SHIFT: begin
                issue     = (r_rd_idx > CNT_W'(r_hit_idx));
                n_chk_vld = issue;
                n_chk_idx = r_rd_idx[IDX_W-1:0];
                if (issue) begin
                    n_rd_idx = r_rd_idx - CNT_W'(1);
                end
                if (r_chk_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_idx + IDX_W'(1);
                end else if (!issue) begin
                    n_state = ffsa_pkg::S_SPLIT_HI;
                end
            end

            ffsa_pkg::S_SPLIT_HI: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx + IDX_W'(1);
                ram_wdata = '{start: r_hit.start + r_req.size,
                              len:   r_hit.len - r_req.size,
                              free:  1'b1};
                n_state   = ffsa_pkg::S_SPLIT_LO;
            end

            ffsa_pkg::S_SPLIT_LO: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
                ram_wdata = '{start: r_hit.start, len: r_req.size, free: 1'b0};
                n_count   = r_count + CNT_W'(1);
                n_addr    = r_hit.start;
                n_state   = ffsa_pkg::S_FIN;
            end

            ffsa_pkg::S_FIN: begin
                if (!r_rsp_vld || i_rsp_ready) begin
                    n_rsp_vld = 1'b1;
                    n_rsp     = '{address: r_addr[ffsa_pkg::ADDR_W-1:0],
                                  status:  r_status};
                    n_state   = ffsa_pkg::S_IDLE;
                end
            end

            default: n_state = ffsa_pkg::S_INIT;
        endcase

        // A size write rebuilds the table; the user must write it only while idle, the block does not enforce this.
        if (i_cfg_we) begin
            n_total = cfg_val;
            n_state = ffsa_pkg::S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffsa_pkg::S_INIT;
            r_count   <= CNT_W'(1);
            r_chk_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_total   <= RESET_TOTAL;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_rsp_vld <= n_rsp_vld;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_hit_idx <= n_hit_idx;
        r_wr_idx  <= n_wr_idx;
        r_hit     <= n_hit;
        r_acc     <= n_acc;
        r_req     <= n_req;
        r_status  <= n_status;
        r_addr    <= n_addr;
        r_rsp     <= n_rsp;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= FULL_COUNT)
        else $error("segment count out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_req_ready)
        else $error("request taken while a previous one is in progress");

    a_split_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffsa_pkg::S_SPLIT_LO && !i_cfg_we)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("split did not add exactly one segment");

    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ffsa_pkg::ST_OK) |-> o_rsp.address == '0)
        else $error("address given with a failing status");

endmodule
